FILE: rtl/itoa_pkg.sv
package itoa_pkg;

  // conversion kinds
  localparam logic [1:0] ACT_SDEC = 2'd0;
  localparam logic [1:0] ACT_UDEC = 2'd1;
  localparam logic [1:0] ACT_HEX  = 2'd2;
  // kinds with the high bit set print in hex
  localparam int unsigned ACT_HEX_BIT = 1;

  localparam int unsigned MAX_CHARS = 11;
  localparam int unsigned CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_CHARS);

  // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam logic [31:0] RADIX_DEC   = 32'd10;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  action;
  } item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } text_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIGIT,
    ST_SIGN,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mult;
    logic digit;
    logic sign;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic load_hex;
    logic hex;
    logic neg;
    logic mag_done;
    logic emit_last;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'b0000, d};
    end else begin
      c = CHAR_A + {4'b0000, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

FILE: rtl/itoa_ctrl.sv
module itoa_ctrl import itoa_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = sts.load_hex ? ST_DIGIT : ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (sts.mag_done) begin
          state_next = sts.neg ? ST_SIGN : ST_EMIT;
        end else begin
          state_next = sts.hex ? ST_DIGIT : ST_MUL;
        end
      end
      ST_SIGN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      ST_MUL:   cmd.mult  = 1'b1;
      ST_DIGIT: cmd.digit = 1'b1;
      ST_SIGN:  cmd.sign  = 1'b1;
      ST_EMIT:  cmd.emit  = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/itoa_dp.sv
module itoa_dp import itoa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t item,
  input  cmd_t  cmd,
  output sts_t  sts,
  output logic  text_valid,
  input  logic  text_ready,
  output text_t text
);

  logic [31:0]      mag;
  logic [63:0]      prod;
  logic             hex;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       chars [MAX_CHARS];

  logic             load_neg;
  logic [28:0]      quot;
  logic [31:0]      quot10;
  logic [31:0]      rem_full;
  logic [3:0]       digit;
  logic [31:0]      mag_next;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  assign load_neg = (item.action == ACT_SDEC) && item.value[31];

  // quotient and remainder by ten from the registered product
  assign quot     = prod[63:RECIP_SHIFT];
  assign quot10   = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = mag - quot10;

  assign digit    = hex ? mag[3:0] : rem_full[3:0];
  assign mag_next = hex ? {4'b0000, mag[31:4]} : {3'b000, quot};

  assign wr_idx = cnt[IDX_W-1:0];
  assign rd_idx = IDX_W'(cnt - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= load_neg ? (~item.value + 32'd1) : item.value;
      hex <= item.action[ACT_HEX_BIT];
      neg <= load_neg;
    end else if (cmd.digit) begin
      mag <= mag_next;
    end
    if (cmd.mult) begin
      prod <= 64'(mag) * 64'(RECIP_10);
    end
    if (cmd.digit) begin
      chars[wr_idx] <= digit_char(digit);
    end else if (cmd.sign) begin
      chars[wr_idx] <= CHAR_MINUS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.digit || cmd.sign) begin
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.emit) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (cmd.emit) begin
      text_valid <= 1'b1;
    end else if (text_ready) begin
      text_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      text.char_code <= chars[rd_idx];
      text.last      <= (cnt == CNT_W'(1));
    end
  end

  assign sts.load_hex  = item.action[ACT_HEX_BIT];
  assign sts.hex       = hex;
  assign sts.neg       = neg;
  assign sts.mag_done  = (mag_next == 32'd0);
  assign sts.emit_last = (cnt == CNT_W'(1));
  assign sts.out_free  = !text_valid || text_ready;

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> cnt != '0)
    else $error("emit from empty buffer");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (cmd.digit || cmd.sign) |-> cnt < CNT_W'(MAX_CHARS))
    else $error("character buffer overflow");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.digit && !hex) |-> rem_full < RADIX_DEC)
    else $error("decimal remainder out of range");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cnt == '0)
    else $error("count not cleared on load");

endmodule

FILE: rtl/integer_to_ascii_formatter.sv
// channel  dir  handshake                payload
// item     in   item_valid / item_ready  item_t: value[31:0], action[1:0]
// text     out  text_valid / text_ready  text_t: char_code[7:0], last
//
// decimal: load, then per digit a multiply by the reciprocal of ten followed
//   by the quotient/remainder step, a minus sign if negative, then the characters out
// hex: load, then a digit step per nibble with no multiply, then the characters out
// worst case "-2147483648": ten digits through the divide loop, a sign, eleven characters
// rst (synchronous) returns the controller to idle and drops text_valid
// a stalled text beat holds in the output register; the next item is taken
//   while the final character of the previous one still waits
module integer_to_ascii_formatter import itoa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  text_valid,
  input  logic  text_ready,
  output text_t text
);

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: load, digit loop, optional sign, character emission
  itoa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // magnitude register, divide-by-ten unit, character buffer, output stage
  itoa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cmd        (cmd),
    .sts        (sts),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text)
  );

endmodule
